[rtl/rpm_pkg.sv]
// Shared types, constants and functions of the route prefix matcher.
// No dependencies; every rtl module refers to this package by scoped names.
`default_nettype none
package rpm_pkg;

    localparam int ROUTES = 16;
    localparam int IDX_W  = $clog2(ROUTES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int CLZ_W  = 6;

    localparam logic [CNT_W-1:0] ROUTES_CNT = CNT_W'(ROUTES);

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } rpm_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
    } rpm_entry_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        rpm_entry_t        entry;
    } rpm_write_t;

    typedef struct packed {
        logic              take;
        logic [CLZ_W-1:0]  clz;
    } rpm_eval_t;

    // Network mask of a prefix length; lengths of 32 and above give a full mask.
    function automatic logic [ADDR_W-1:0] length_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len >= LEN_W'(ADDR_W))
            m = '1;
        else
            m = ~({ADDR_W{1'b1}} >> len);
        return m;
    endfunction

    // Leading zeros: smear the top one downward, then count the ones.
    function automatic logic [CLZ_W-1:0] lead_zero_count(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        x = x | (x >> 1);
        x = x | (x >> 2);
        x = x | (x >> 4);
        x = x | (x >> 8);
        x = x | (x >> 16);
        x = x - ((x >> 1) & 32'h5555_5555);
        x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
        x = (x + (x >> 4)) & 32'h0f0f_0f0f;
        x = x + (x >> 8);
        x = x + (x >> 16);
        x = x & 32'h0000_003f;
        return CLZ_W'(7'd32 - x[6:0]);
    endfunction

endpackage
`default_nettype wire

[rtl/rpm_table.sv]
// Route table memory: one write port, one read port with registered data.
// Depends on rpm_pkg for the entry and write-request types.
`default_nettype none
module rpm_table (
    input  wire logic                    clk,
    input  wire rpm_pkg::rpm_write_t     wr,
    input  wire logic [rpm_pkg::IDX_W-1:0] rd_addr,
    output rpm_pkg::rpm_entry_t          rd_entry
);

    rpm_pkg::rpm_entry_t mem_reg [rpm_pkg::ROUTES];
    rpm_pkg::rpm_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem_reg[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule
`default_nettype wire

[rtl/rpm_match_unit.sv]
// Shared match unit: masked prefix compare, leading-zero count, best-so-far test.
// Depends on rpm_pkg for length_mask, lead_zero_count and rpm_eval_t.
`default_nettype none
module rpm_match_unit (
    input  wire logic [rpm_pkg::ADDR_W-1:0] target,
    input  wire rpm_pkg::rpm_entry_t        entry,
    input  wire logic                       best_found,
    input  wire logic [rpm_pkg::CLZ_W-1:0]  best_clz,
    output rpm_pkg::rpm_eval_t              result
);

    logic [rpm_pkg::ADDR_W-1:0] mask;
    logic [rpm_pkg::CLZ_W-1:0]  clz;
    logic                       hit;

    always_comb
    begin
        mask = rpm_pkg::length_mask(entry.length);
        hit  = ((target & mask) == entry.prefix);
        clz  = rpm_pkg::lead_zero_count(target ^ entry.prefix);
        result.clz  = clz;
        // strict compare keeps the lowest slot on ties
        result.take = hit && (!best_found || (clz > best_clz));
    end

endmodule
`default_nettype wire

[rtl/route_prefix_match_by_clz_unit.sv]
// Top level of the route prefix matcher: sequencer, config register, output word.
// Depends on rpm_pkg, rpm_table and rpm_match_unit.
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_*      | in  | entry_index 4, entry_prefix 32, entry_length 6,  | mode
//           |     | target_address 32, zero pad 6                    |
//  m_*      | out | match_index 4, match_clz 6, zero pad 6           | match_found
//  cfg_*    | in  | cfg_wdata = routes_in_use 5                      | -
//
// A write word leaves s_tready high.
// A lookup scans N = min(routes_in_use, 16) entries: one table entry per
// cycle through the single match unit, fed by the table's one read port.
// s_tready stays low from lookup accept until the result is loaded into the
// output register; a stalled m_tready holds the sequencer in its last step.
// rst_n clears the sequencer, routes_in_use and the output valid; table
// contents are undefined until written.
`default_nettype none
module route_prefix_match_by_clz_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // entry_index, entry_prefix, entry_length, target_address
    input  wire logic        s_tuser,  // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // match_index, match_clz
    output logic             m_tuser,  // match_found
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata // routes_in_use
);

    rpm_pkg::rpm_state_t               state_reg, state_next;
    logic [4:0]                        routes_reg;
    logic [rpm_pkg::CNT_W-1:0]         limit_reg, limit_next;
    logic [rpm_pkg::IDX_W-1:0]         eval_reg, eval_next;
    logic [rpm_pkg::ADDR_W-1:0]        target_reg, target_next;
    logic                              best_found_reg, best_found_next;
    logic [rpm_pkg::IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [rpm_pkg::CLZ_W-1:0]         best_clz_reg, best_clz_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_found_reg, out_found_next;
    logic [rpm_pkg::IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic [rpm_pkg::CLZ_W-1:0]         out_clz_reg, out_clz_next;

    logic                              in_acc;
    logic [rpm_pkg::CNT_W-1:0]         limit_in;
    logic [rpm_pkg::IDX_W-1:0]         rd_addr;
    rpm_pkg::rpm_write_t               wr;
    rpm_pkg::rpm_entry_t               rd_entry;
    rpm_pkg::rpm_eval_t                ev;

    assign s_tready = (state_reg == rpm_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign limit_in = (rpm_pkg::CNT_W'(routes_reg) > rpm_pkg::ROUTES_CNT)
                      ? rpm_pkg::ROUTES_CNT : rpm_pkg::CNT_W'(routes_reg);

    assign wr.en           = in_acc && (s_tuser == rpm_pkg::MODE_WRITE);
    assign wr.addr         = s_tdata[3:0];
    assign wr.entry.prefix = s_tdata[35:4];
    assign wr.entry.length = s_tdata[41:36];

    // first read goes out with the accept, then one entry ahead of the compare
    assign rd_addr = (state_reg == rpm_pkg::ST_IDLE) ? '0
                     : eval_reg + rpm_pkg::IDX_W'(1);

    rpm_table u_table (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    rpm_match_unit u_match (
        .target     (target_reg),
        .entry      (rd_entry),
        .best_found (best_found_reg),
        .best_clz   (best_clz_reg),
        .result     (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpm_pkg::ST_IDLE;
            routes_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                routes_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg      <= limit_next;
        eval_reg       <= eval_next;
        target_reg     <= target_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_clz_reg   <= best_clz_next;
        out_found_reg  <= out_found_next;
        out_idx_reg    <= out_idx_next;
        out_clz_reg    <= out_clz_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        eval_next       = eval_reg;
        target_next     = target_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_clz_next   = best_clz_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_idx_next    = out_idx_reg;
        out_clz_next    = out_clz_reg;

        unique case (state_reg)
            rpm_pkg::ST_IDLE:
            begin
                if (in_acc && (s_tuser == rpm_pkg::MODE_LOOKUP))
                begin
                    target_next     = s_tdata[73:42];
                    limit_next      = limit_in;
                    eval_next       = '0;
                    best_found_next = 1'b0;
                    best_idx_next   = '0;
                    best_clz_next   = '0;
                    state_next      = (limit_in == '0) ? rpm_pkg::ST_DONE
                                                       : rpm_pkg::ST_SCAN;
                end
            end
            rpm_pkg::ST_SCAN:
            begin
                if (ev.take)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = eval_reg;
                    best_clz_next   = ev.clz;
                end
                if (({1'b0, eval_reg} + rpm_pkg::CNT_W'(1)) == limit_reg)
                    state_next = rpm_pkg::ST_DONE;
                else
                    eval_next = eval_reg + rpm_pkg::IDX_W'(1);
            end
            rpm_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = best_found_reg;
                    out_idx_next   = best_idx_reg;
                    out_clz_next   = best_clz_reg;
                    state_next     = rpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpm_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {6'd0, out_clz_reg, out_idx_reg};

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[9:0] == 10'd0))
        else $error("no-match word carries nonzero index or count");

    a_clz_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:4] <= 6'd32))
        else $error("leading-zero count above 32");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpm_pkg::ST_SCAN) |-> ({1'b0, eval_reg} < limit_reg))
        else $error("scan pointer past the routes in use");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == rpm_pkg::MODE_LOOKUP)) |=> !s_tready)
        else $error("lookup accepted but block still ready");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == rpm_pkg::MODE_WRITE)) |=> s_tready)
        else $error("table write left the block busy");

endmodule
`default_nettype wire
